/* hw/rtl/sdiv_pkg.sv */
// ---------------------------------------------------------------------------
// sdiv_pkg: shared types and constants for the saturating signed divider
// Holds the field widths, the saturation limits and the structs that
// travel down the division pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package sdiv_pkg;

   localparam int WIDE_W   = 64;
   localparam int NARROW_W = 32;
   localparam int DIV_W    = 32;
   localparam int STEPS    = WIDE_W;

   localparam logic [WIDE_W-1:0]   WIDE_MAX   = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic [WIDE_W-1:0]   WIDE_MIN   = {1'b1, {(WIDE_W-1){1'b0}}};
   localparam logic [NARROW_W-1:0] NARROW_MAX = {1'b0, {(NARROW_W-1){1'b1}}};
   localparam logic [NARROW_W-1:0] NARROW_MIN = {1'b1, {(NARROW_W-1){1'b0}}};

   // Magnitude limits of the quotient that still fit the narrow result.
   localparam logic [WIDE_W-1:0] POS_LIMIT = {{(WIDE_W-NARROW_W){1'b0}}, NARROW_MAX};
   localparam logic [WIDE_W-1:0] NEG_LIMIT = {{(WIDE_W-NARROW_W){1'b0}}, NARROW_MIN};

   typedef struct packed {
      logic valid;
      logic neg;
      logic dbz;
   } sdiv_ctl_type;

   // rem is the partial remainder, work holds the dividend bits still to be
   // consumed at the top and the quotient bits produced so far at the bottom.
   typedef struct packed {
      logic [DIV_W-1:0]  rem;
      logic [WIDE_W-1:0] work;
      logic [DIV_W-1:0]  divisor;
   } sdiv_data_type;

endpackage

`default_nettype wire

/* hw/rtl/sdiv_prep.sv */
// ---------------------------------------------------------------------------
// sdiv_prep: entry stage of the divider
// Takes the numerator's magnitude, notes its sign and a zero divisor, and
// loads the first pipeline register.
// ---------------------------------------------------------------------------
`default_nettype none

module sdiv_prep
   import sdiv_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      accept,
   input  wire  [WIDE_W-1:0]        numerator,
   input  wire  [DIV_W-1:0]         divisor,
   output sdiv_ctl_type             ctl_out,
   output sdiv_data_type            data_out
);

   sdiv_ctl_type  ctl_ff, ctl_in;
   sdiv_data_type data_ff, data_in;

   always_comb begin
      ctl_in.valid    = accept;
      ctl_in.neg      = numerator[WIDE_W-1];
      ctl_in.dbz      = (divisor == '0);
      data_in.rem     = '0;
      // Negation wraps, so the most negative value gives 2^63 as unsigned.
      data_in.work    = numerator[WIDE_W-1] ? (~numerator + 1'b1) : numerator;
      data_in.divisor = divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.neg <= ctl_in.neg;
      ctl_ff.dbz <= ctl_in.dbz;
      data_ff    <= data_in;
   end

   assign ctl_out  = ctl_ff;
   assign data_out = data_ff;

endmodule

`default_nettype wire

/* hw/rtl/sdiv_step.sv */
// ---------------------------------------------------------------------------
// sdiv_step: one restoring division stage
// Shifts in one dividend bit, trial-subtracts the divisor and registers the
// new remainder and one quotient bit.
// ---------------------------------------------------------------------------
`default_nettype none

module sdiv_step
   import sdiv_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  sdiv_ctl_type             ctl_in_s,
   input  sdiv_data_type            data_in_s,
   output sdiv_ctl_type             ctl_out,
   output sdiv_data_type            data_out
);

   sdiv_ctl_type        ctl_ff;
   sdiv_data_type       data_ff, data_in;
   logic [DIV_W:0]      trial;
   logic [DIV_W+1:0]    diff;
   logic                qbit;

   always_comb begin
      trial = {data_in_s.rem, data_in_s.work[WIDE_W-1]};
      diff  = {1'b0, trial} - {2'b00, data_in_s.divisor};
      // No borrow means the divisor fitted; the remainder then stays below it.
      qbit  = ~diff[DIV_W+1];
      data_in.rem     = qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      data_in.work    = {data_in_s.work[WIDE_W-2:0], qbit};
      data_in.divisor = data_in_s.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in_s.valid;
      end
      ctl_ff.neg <= ctl_in_s.neg;
      ctl_ff.dbz <= ctl_in_s.dbz;
      data_ff    <= data_in;
   end

   assign ctl_out  = ctl_ff;
   assign data_out = data_ff;

endmodule

`default_nettype wire

/* hw/rtl/sdiv_post.sv */
// ---------------------------------------------------------------------------
// sdiv_post: result stage of the divider
// Restores the sign, applies the zero-divisor values and clamps the narrow
// result, then registers the outgoing item.
// ---------------------------------------------------------------------------
`default_nettype none

module sdiv_post
   import sdiv_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  sdiv_ctl_type             ctl_in_s,
   input  wire  [WIDE_W-1:0]        quotient,
   output logic                     valid,
   output logic [WIDE_W-1:0]        quotient_wide,
   output logic [NARROW_W-1:0]      quotient_narrow,
   output logic                     divide_by_zero
);

   logic                valid_ff;
   logic [WIDE_W-1:0]   wide_ff, wide_in, negated;
   logic [NARROW_W-1:0] narrow_ff, narrow_in;
   logic                dbz_ff;

   always_comb begin
      negated = ~quotient + 1'b1;
      if (ctl_in_s.dbz) begin
         wide_in   = ctl_in_s.neg ? WIDE_MIN : WIDE_MAX;
         narrow_in = ctl_in_s.neg ? NARROW_MIN : NARROW_MAX;
      end else if (ctl_in_s.neg) begin
         wide_in   = negated;
         narrow_in = (quotient > NEG_LIMIT) ? NARROW_MIN : negated[NARROW_W-1:0];
      end else begin
         wide_in   = quotient;
         narrow_in = (quotient > POS_LIMIT) ? NARROW_MAX : quotient[NARROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_in_s.valid;
      end
      wide_ff   <= wide_in;
      narrow_ff <= narrow_in;
      dbz_ff    <= ctl_in_s.dbz;
   end

   assign valid           = valid_ff;
   assign quotient_wide   = wide_ff;
   assign quotient_narrow = narrow_ff;
   assign divide_by_zero  = dbz_ff;

endmodule

`default_nettype wire

/* hw/rtl/signed_div_64_by_32_saturating.sv */
// ---------------------------------------------------------------------------
// signed_div_64_by_32_saturating: pipelined signed 64 by unsigned 32 divider
// Divides a signed 64-bit numerator by an unsigned 32-bit divisor, truncating
// toward zero, and gives the 64-bit quotient and its signed 32-bit clamp.
// ---------------------------------------------------------------------------
// The divider takes a new item on every clock cycle: an item is accepted at
// each rising edge where start is high and busy is low, and busy is high only
// while reset is held. Each item passes through the entry, the 64 step and
// the result registers, and leaves in the order of acceptance, as a
// single-cycle pulse on rsp_valid with the results alongside; the receiver
// must take it then, since nothing holds results back. The pipeline follows
// the restoring division itself: one entry stage forms the numerator's
// magnitude, then 64 stages each decide one quotient bit with a 33-bit trial
// subtraction, and one result stage restores the sign and clamps. A zero
// divisor gives the largest positive value, or the most negative one for a
// negative numerator, on both results and raises rsp_divide_by_zero. The
// block holds no state beyond the items in flight, and reset discards those.
// ---------------------------------------------------------------------------
`default_nettype none

module signed_div_64_by_32_saturating
   import sdiv_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire  [WIDE_W-1:0]        req_numerator,
   input  wire  [DIV_W-1:0]         req_divisor,
   output logic                     rsp_valid,
   output logic [WIDE_W-1:0]        rsp_quotient_wide,
   output logic [NARROW_W-1:0]      rsp_quotient_narrow,
   output logic                     rsp_divide_by_zero
);

   // Stage 0 is the entry register; stage STEPS holds the finished quotient.
   sdiv_ctl_type  stage_ctl  [0:STEPS];
   sdiv_data_type stage_data [0:STEPS];
   logic          accept;

   // The pipeline never stalls, so the only time an item is refused is
   // while the pipeline registers are being cleared.
   assign busy   = reset;
   assign accept = start & ~busy;

   sdiv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .numerator (req_numerator),
      .divisor   (req_divisor),
      .ctl_out   (stage_ctl[0]),
      .data_out  (stage_data[0])
   );

   // One quotient bit per stage, most significant bit first.
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      sdiv_step u_step (
         .clock     (clock),
         .reset     (reset),
         .ctl_in_s  (stage_ctl[i]),
         .data_in_s (stage_data[i]),
         .ctl_out   (stage_ctl[i+1]),
         .data_out  (stage_data[i+1])
      );
   end

   sdiv_post u_post (
      .clock           (clock),
      .reset           (reset),
      .ctl_in_s        (stage_ctl[STEPS]),
      .quotient        (stage_data[STEPS].work),
      .valid           (rsp_valid),
      .quotient_wide   (rsp_quotient_wide),
      .quotient_narrow (rsp_quotient_narrow),
      .divide_by_zero  (rsp_divide_by_zero)
   );

endmodule

`default_nettype wire

/* hw/rtl/sdiv_checker.sv */
// ---------------------------------------------------------------------------
// sdiv_checker: port-level checks for the saturating divider
// Checks the consistency of the two quotients and the zero-divisor values
// as seen on the result port.
// ---------------------------------------------------------------------------
`default_nettype none

module sdiv_checker
   import sdiv_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  rsp_valid,
   input  wire  [WIDE_W-1:0]    rsp_quotient_wide,
   input  wire  [NARROW_W-1:0]  rsp_quotient_narrow,
   input  wire                  rsp_divide_by_zero
);

   // Reset discards every item in flight, so no result follows it at once.
   a_no_result_after_reset: assert property (
      @(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe straight after reset");

   // A zero divisor always gives a matching pair of saturated values.
   a_dbz_saturates: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |->
         (rsp_quotient_wide == WIDE_MAX && rsp_quotient_narrow == NARROW_MAX) ||
         (rsp_quotient_wide == WIDE_MIN && rsp_quotient_narrow == NARROW_MIN))
      else $error("zero divisor without saturated results");

   // A wide quotient above the narrow range clamps to the largest value.
   a_clamp_high: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && ($signed(rsp_quotient_wide) > $signed(POS_LIMIT)) |->
         rsp_quotient_narrow == NARROW_MAX)
      else $error("narrow quotient not clamped high");

   // Within the narrow range the two quotients agree bit for bit.
   a_narrow_matches: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && ($signed(rsp_quotient_wide) <= $signed(POS_LIMIT)) &&
         ($signed(rsp_quotient_wide) >= -$signed(NEG_LIMIT)) |->
         rsp_quotient_narrow == rsp_quotient_wide[NARROW_W-1:0])
      else $error("narrow quotient differs from wide quotient");

endmodule

bind signed_div_64_by_32_saturating sdiv_checker u_sdiv_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_quotient_wide   (rsp_quotient_wide),
   .rsp_quotient_narrow (rsp_quotient_narrow),
   .rsp_divide_by_zero  (rsp_divide_by_zero)
);

`default_nettype wire
